FILE: hw/rtl/hafc_pkg.sv
// shared types, constants and helper functions for the hex ascii frame crc8 encoder
// no dependencies
`default_nettype none

package hafc_pkg;

    // frame layout
    localparam int QUAT_COUNT = 32;
    localparam logic [7:0] LAST_POS = 8'(1 + 4 * QUAT_COUNT);
    localparam logic [7:0] COUNT_POS = 8'd1;

    // crc-8 constants
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP = 8'h80;

    // characters
    localparam logic [7:0] FRAME_END = 8'd13;
    localparam int MAX_CHARS = 7;
    localparam logic [2:0] CNT_COUNT_WORD = 3'd2;
    localparam logic [2:0] CNT_DATA_WORD = 3'd4;
    localparam logic [2:0] CNT_TRAILER = 3'd3;

    // characters caused by one word, first character in entry 0
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [2:0]                cnt;
    } t_pack_res;

    // uppercase hex digit for one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
        end else begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

    // crc-8, polynomial 0x07, msb first, over one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hafc_pack.sv
// turns one 16-bit word plus frame state into its characters and the next state
// depends on hafc_pkg
`default_nettype none

module hafc_pack
    import hafc_pkg::*;
(
    input  wire logic [15:0] i_word,
    input  wire logic [7:0]  i_pos,
    input  wire logic [7:0]  i_crc,
    output t_pack_res        o_res,
    output logic [7:0]       o_next_pos,
    output logic [7:0]       o_next_crc
);

    logic       is_count;
    logic       close;
    logic [7:0] h0, h1, h2, h3;
    logic [7:0] c0, c1, c2, c3;
    logic [7:0] crc_digits;
    logic [7:0] t_hi, t_lo;

    assign is_count = (i_pos == COUNT_POS);
    assign close    = (i_pos >= LAST_POS);

    // digits, most significant first; the count word uses its low byte only
    always_comb begin
        if (is_count) begin
            h0 = hex_char(i_word[7:4]);
            h1 = hex_char(i_word[3:0]);
        end else begin
            h0 = hex_char(i_word[15:12]);
            h1 = hex_char(i_word[11:8]);
        end
        h2 = hex_char(i_word[7:4]);
        h3 = hex_char(i_word[3:0]);
    end

    // crc over the emitted digits
    assign c0 = crc8_byte(i_crc, h0);
    assign c1 = crc8_byte(c0, h1);
    assign c2 = crc8_byte(c1, h2);
    assign c3 = crc8_byte(c2, h3);
    assign crc_digits = is_count ? c1 : c3;

    assign t_hi = hex_char(crc_digits[7:4]);
    assign t_lo = hex_char(crc_digits[3:0]);

    // character list and count
    always_comb begin
        o_res.chars = '0;
        o_res.chars[0] = h0;
        o_res.chars[1] = h1;
        if (is_count) begin
            o_res.chars[2] = t_hi;
            o_res.chars[3] = t_lo;
            o_res.chars[4] = FRAME_END;
            o_res.cnt = close ? (CNT_COUNT_WORD + CNT_TRAILER) : CNT_COUNT_WORD;
        end else begin
            o_res.chars[2] = h2;
            o_res.chars[3] = h3;
            o_res.chars[4] = t_hi;
            o_res.chars[5] = t_lo;
            o_res.chars[6] = FRAME_END;
            o_res.cnt = close ? (CNT_DATA_WORD + CNT_TRAILER) : CNT_DATA_WORD;
        end
    end

    // next frame state
    assign o_next_pos = close ? 8'd0 : (i_pos + 8'd1);
    assign o_next_crc = close ? 8'd0 : crc_digits;

endmodule

`default_nettype wire

FILE: hw/rtl/hafc_ser.sv
// result register that sends the characters of one word, one per cycle while the sink is ready
// depends on hafc_pkg
`default_nettype none

module hafc_ser
    import hafc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_pack_res  i_res,
    output logic            o_free,
    output logic            o_tvalid,
    input  wire logic       i_tready,
    output logic [7:0]      o_tdata,
    output logic            o_tlast
);

    logic [MAX_CHARS-1:0][7:0] r_chars;
    logic [2:0]                r_left;
    logic                      take;

    assign take     = o_tvalid && i_tready;
    assign o_tvalid = (r_left != 3'd0);
    assign o_tdata  = r_chars[0];
    assign o_tlast  = (r_left == 3'd1);
    assign o_free   = (r_left == 3'd0) || (o_tlast && i_tready);

    // remaining character count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_load) begin
            r_left <= i_res.cnt;
        end else if (take) begin
            r_left <= r_left - 3'd1;
        end
    end

    // character shift line, head at entry 0
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_chars <= i_res.chars;
        end else if (take) begin
            r_chars <= {8'h00, r_chars[MAX_CHARS-1:1]};
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/hex_ascii_frame_crc8_encoder.sv
// top level of the hex ascii frame crc8 encoder: input register, frame state, serializer
// depends on hafc_pkg, hafc_pack, hafc_ser
`default_nettype none

// Each 16-bit input word becomes uppercase ASCII hex characters sent one per
// cycle on the master side while m_axis_tready is high: 4 for a data word, 2
// for the count word (second word of a frame, low byte), and on the last word
// of a frame the digits are followed by the CRC-8 (poly 0x07, init 0, over the
// digits) as 2 hex digits and a carriage return. tlast marks the final character
// of each word. A word waiting in the input register is folded into the
// serializer on the cycle its last character leaves, so the output runs without
// gaps. With the serializer idle, a taken word passes through the input register
// and then the serializer register before its first character is valid.
module hex_ascii_frame_crc8_encoder
    import hafc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] word_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] char_out
    output logic             m_axis_tlast    // last_of_run
);

    logic        r_in_valid;
    logic [15:0] r_in_word;
    logic [7:0]  r_pos;
    logic [7:0]  r_crc;
    logic [7:0]  n_pos;
    logic [7:0]  n_crc;
    logic        ser_free;
    logic        load;
    t_pack_res   pack_res;

    assign load          = r_in_valid && ser_free;
    assign s_axis_tready = !r_in_valid || ser_free;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_word <= s_axis_tdata;
        end
    end

    // character and crc logic
    hafc_pack u_pack (
        .i_word     (r_in_word),
        .i_pos      (r_pos),
        .i_crc      (r_crc),
        .o_res      (pack_res),
        .o_next_pos (n_pos),
        .o_next_crc (n_crc)
    );

    // frame state advances when a word moves to the serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 8'd0;
            r_crc <= 8'd0;
        end else if (load) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // output serializer
    hafc_ser u_ser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_res    (pack_res),
        .o_free   (ser_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    // position never runs past the last word of a frame
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("frame position out of range");

    // closing the frame clears crc and position
    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && (r_pos >= LAST_POS) |=> (r_pos == 8'd0) && (r_crc == 8'd0))
        else $error("frame state not cleared at frame end");

    // a waiting word is not lost while the serializer is busy
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !ser_free |=> r_in_valid && $stable(r_in_word))
        else $error("pending word dropped");

    // after the last character with nothing loaded, the output goes idle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast && !load |=> !m_axis_tvalid)
        else $error("output valid after last character");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// self-checking testbench for the hex ascii frame crc8 encoder: frames of 16-bit words in,
// hex characters with a crc trailer out, checked against an in-bench frame predictor
// depends on hafc_pkg and hex_ascii_frame_crc8_encoder
`timescale 1ns / 1ps

module tb_top;
    import hafc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_WORDS    = 80;

    // one expected character on the output stream
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_rec_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'h0000;   // [15:0] word_value
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;              // [7:0] char_out
    logic        m_axis_tlast;              // last_of_run

    // predictor state: crc over the digits so far and index of the next word
    logic [7:0]  frame_crc = 8'h00;
    logic [7:0]  frame_pos = 8'h00;
    char_rec_t   expected_chars[$];

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int error_count = 0;
    int idle_cycles = 0;

    hex_ascii_frame_crc8_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ascii code of one uppercase hex digit
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] code;
        if (nib > 4'd9) begin
            code = 8'd65 + 8'(nib - 4'd10);
        end else begin
            code = 8'd48 + 8'(nib);
        end
        return code;
    endfunction

    // crc-8 step, poly 0x07, msb first, one character folded in
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] ch);
        logic [7:0] r;
        logic       fb;
        int         b;
        r = crc ^ ch;
        for (b = 0; b < 8; b++) begin
            fb = (r & CRC_TOP) != 8'h00;
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic last);
        char_rec_t rec;
        rec.ch   = ch;
        rec.last = last;
        expected_chars.push_back(rec);
    endtask

    // expected characters for one accepted word, advancing the frame state
    task automatic predict_word(input logic [15:0] w);
        int         n_digits;
        int         i;
        logic       closing;
        logic [7:0] ch;
        n_digits = (frame_pos == COUNT_POS) ? 2 : 4;
        closing  = (frame_pos >= LAST_POS);
        for (i = n_digits - 1; i >= 0; i--) begin
            ch = hex_ascii(w[4*i +: 4]);
            frame_crc = crc_update(frame_crc, ch);
            push_char(ch, !closing && (i == 0));
        end
        if (closing) begin
            // trailer digits and carriage return stay out of the crc
            push_char(hex_ascii(frame_crc[7:4]), 1'b0);
            push_char(hex_ascii(frame_crc[3:0]), 1'b0);
            push_char(FRAME_END, 1'b1);
            frame_crc = 8'h00;
            frame_pos = 8'h00;
        end else begin
            frame_pos = frame_pos + 8'd1;
        end
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // send one word, with random source gaps ahead of it
    task automatic send_word(input logic [15:0] w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_word(w);
    endtask

    // drop valid and hold off until every expected character has come out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_chars.size() != 0) @(posedge i_clk);
    endtask

    // mostly uniform words, some corner values
    function automatic logic [15:0] random_word();
        logic [15:0] w;
        case ($urandom_range(0, 7))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w = {1'b1, 15'($urandom_range(0, 32767))};
            default: w = 16'($urandom_range(0, 65535));
        endcase
        return w;
    endfunction

    // output check, sink stalls and activity tracking for the watchdog
    always @(posedge i_clk) begin
        char_rec_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                note_error($sformatf("unexpected char %02h last %0b",
                                     m_axis_tdata, m_axis_tlast));
            end else begin
                want = expected_chars.pop_front();
                if (m_axis_tdata !== want.ch || m_axis_tlast !== want.last) begin
                    note_error($sformatf("char exp %02h/last %0b got %02h/last %0b",
                                         want.ch, want.last, m_axis_tdata, m_axis_tlast));
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // corner values of the sample, count and quaternion fields
    task automatic test_field_extremes();
        logic [15:0] quat_words[$];
        int          i;
        quat_words = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0123, 16'h4567,
                       16'h89AB, 16'hCDEF, 16'hFEDC, 16'hBA98, 16'h7654, 16'h3210,
                       16'h0001, 16'h8001, 16'hAAAA, 16'h5555, 16'h00FF, 16'hFF00};
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(16'hFFFF);                // sample word
        send_word(16'hA53C);                // count word, high byte dropped
        for (i = 0; i < quat_words.size(); i++) begin
            send_word(quat_words[i]);
        end
        hold_until_drained();
    endtask

    // random words under the given source idle and sink stall mix, frame state carried across calls
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int i;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (i = 0; i < PHASE_WORDS; i++) begin
            send_word(random_word());
        end
        hold_until_drained();
    endtask

    // data words against sink stalls, with the source pausing mid-frame until the output drains
    task automatic test_hold_until_drained();
        int i;
        src_idle_pct   = 0;
        sink_stall_pct = 30;
        for (i = 0; i < 6; i++) begin
            send_word(random_word());
            if (i == 2) begin
                hold_until_drained();
            end
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(64, 0);
        test_random_traffic(0, 64);
        test_random_traffic(13, 13);
        test_hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_chars.size() != 0) begin
            note_error($sformatf("%0d chars never came out", expected_chars.size()));
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // stop a hung run: too long with no word moving on either side
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
